FILE: hw/rtl/dcs_pkg.sv
// shared types and constants for the dual character stack engine
// item structs, opcode and sequencer state codes; no dependencies
package dcs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam logic [7:0] FILL_CHAR = 8'd35;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_XFER = 2'd2,
        OP_PAL  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_XFER_WR,
        S_PAL_HI,
        S_PAL_CMP,
        S_FINISH
    } state_t;

    typedef struct packed {
        op_t        opcode;
        logic       stack_sel;
        logic [7:0] char_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       is_empty;
        logic       is_full;
        logic       is_palindrome;
        logic [4:0] depth_now;
    } out_item_t;

endpackage

FILE: hw/rtl/dcs_stack_ram.sv
// slot storage for both stacks, addressed as {stack, slot}
// one write port, one read port with registered data; uses dcs_pkg
module dcs_stack_ram #(
    parameter int DEPTH = dcs_pkg::DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH):0]     wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH):0]     rd_addr,
    output logic [7:0]                 rd_data
);
    import dcs_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH) + 1;
    localparam int ENTRIES = 2 ** ADDR_W;

    logic [7:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/dual_char_stack_engine_top.sv
// top level of the dual character stack engine: sequencer, stack counters, result register
// depends on dcs_pkg and dcs_stack_ram
//
// two bounded byte stacks, A and B, of DEPTH slots each, share one slot ram with a single
// write port and a single registered read port, and a small sequencer runs each item as a
// series of steps; in_ready is high only while the sequencer is idle. push writes and then
// finishes; pop reads the top, takes the ram data and then finishes (an empty stack goes
// straight to finishing); transfer reads the source top (skipped for an empty source), then
// writes the byte into the other stack; a palindrome query on a stack of n items compares
// up to floor(n/2) slot pairs, paced by the one ram read port: each slot pair takes two reads
// and the one byte comparator, and a mismatch ends the walk early. the finishing step waits
// for as long as the output register still holds an untaken result. the edge that loads the
// result also returns the sequencer to idle, so in_ready is high again in the next cycle.
// the result sits in an output register, so a new item can be taken while the previous
// result waits for out_ready. slot contents are never read unless a push or a transfer
// wrote them since reset, so the ram needs no clearing pass and every slot behaves as if it
// held '#' after reset; counts are flip-flops cleared by reset.
module dual_char_stack_engine_top #(
    parameter int DEPTH = dcs_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dcs_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output dcs_pkg::out_item_t  out_item
);
    import dcs_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int ADDR_W = IDX_W + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;

    // sequencer and control
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  top_a_reg, top_a_next;
    logic [CNT_W-1:0]  top_b_reg, top_b_next;
    logic              out_valid_reg, out_valid_next;

    // payload held while an item is worked on
    in_item_t          item_reg, item_next;
    logic [7:0]        res_reg, res_next;
    logic              pal_reg, pal_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [7:0]        lo_data_reg, lo_data_next;
    out_item_t         out_reg, out_next;

    // ram port
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // views of the selected and the other stack
    logic              sel;
    logic [CNT_W-1:0]  top_sel, top_oth, top_inc, oth_inc, top_dec;
    logic              sel_full, oth_full;
    logic [IDX_W-1:0]  lo_inc, hi_dec;
    logic [IDX_W:0]    lo_plus2;
    logic [EXT_W-1:0]  depth_ext;

    dcs_stack_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign sel      = item_reg.stack_sel;
    assign top_sel  = sel ? top_b_reg : top_a_reg;
    assign top_oth  = sel ? top_a_reg : top_b_reg;
    assign top_inc  = top_sel + CNT_W'(1);
    assign oth_inc  = top_oth + CNT_W'(1);
    assign top_dec  = top_sel - CNT_W'(1);
    assign sel_full = (top_sel >= CNT_W'(DEPTH));
    assign oth_full = (top_oth >= CNT_W'(DEPTH));
    assign lo_inc   = lo_reg + IDX_W'(1);
    assign hi_dec   = hi_reg - IDX_W'(1);
    assign lo_plus2 = {1'b0, lo_reg} + (IDX_W + 1)'(2);
    // count after the operation, low five bits only
    assign depth_ext = EXT_W'(top_sel);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        top_a_next     = top_a_reg;
        top_b_next     = top_b_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        pal_next       = pal_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        lo_data_next   = lo_data_reg;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = {sel, top_sel[IDX_W-1:0]};
        wr_data        = item_reg.char_in;
        rd_en          = 1'b0;
        rd_addr        = {sel, top_dec[IDX_W-1:0]};

        // result taken downstream frees the output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_item;
                    res_next   = 8'd0;
                    pal_next   = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (item_reg.opcode)
                    OP_PUSH:
                    begin
                        // push onto a full stack is dropped
                        if (!sel_full)
                        begin
                            wr_en = 1'b1;
                            if (sel)
                                top_b_next = top_inc;
                            else
                                top_a_next = top_inc;
                        end
                        state_next = S_FINISH;
                    end

                    OP_POP, OP_XFER:
                    begin
                        if (top_sel == '0)
                        begin
                            // empty source yields the fill char
                            res_next   = FILL_CHAR;
                            state_next = (item_reg.opcode == OP_XFER) ? S_XFER_WR : S_FINISH;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                            if (sel)
                                top_b_next = top_dec;
                            else
                                top_a_next = top_dec;
                            state_next = S_POP_WAIT;
                        end
                    end

                    OP_PAL:
                    begin
                        pal_next = 1'b1;
                        lo_next  = '0;
                        hi_next  = top_dec[IDX_W-1:0];
                        if (top_sel < CNT_W'(2))
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = {sel, {IDX_W{1'b0}}};
                            state_next = S_PAL_HI;
                        end
                    end

                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_POP_WAIT:
            begin
                res_next   = rd_data;
                state_next = (item_reg.opcode == OP_XFER) ? S_XFER_WR : S_FINISH;
            end

            S_XFER_WR:
            begin
                // byte is lost when the other stack is full
                if (!oth_full)
                begin
                    wr_en   = 1'b1;
                    wr_addr = {~sel, top_oth[IDX_W-1:0]};
                    wr_data = res_reg;
                    if (sel)
                        top_a_next = oth_inc;
                    else
                        top_b_next = oth_inc;
                end
                state_next = S_FINISH;
            end

            S_PAL_HI:
            begin
                lo_data_next = rd_data;
                rd_en        = 1'b1;
                rd_addr      = {sel, hi_reg};
                state_next   = S_PAL_CMP;
            end

            S_PAL_CMP:
            begin
                if (rd_data != lo_data_reg)
                begin
                    pal_next   = 1'b0;
                    state_next = S_FINISH;
                end
                else
                begin
                    lo_next = lo_inc;
                    hi_next = hi_dec;
                    // another pair left while the ends are still apart
                    if ({1'b0, hi_reg} > lo_plus2)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = {sel, lo_inc};
                        state_next = S_PAL_HI;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.char_out      = res_reg;
                    out_next.is_empty      = (top_sel == '0);
                    out_next.is_full       = sel_full;
                    out_next.is_palindrome = pal_reg;
                    out_next.depth_now     = depth_ext[4:0];
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_a_reg     <= '0;
            top_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_a_reg     <= top_a_next;
            top_b_reg     <= top_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        res_reg     <= res_next;
        pal_reg     <= pal_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        lo_data_reg <= lo_data_next;
        out_reg     <= out_next;
    end

    // counts stay within the stack depth
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (top_a_reg <= CNT_W'(DEPTH)) && (top_b_reg <= CNT_W'(DEPTH)))
        else $error("stack count beyond depth");

    // an accepted item always starts the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted item did not start execution");

    // the palindrome walk leaves both stacks untouched
    a_pal_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAL_HI || state_reg == S_PAL_CMP)
        |=> ($stable(top_a_reg) && $stable(top_b_reg)))
        else $error("stack count changed during palindrome walk");

    // writes go only into a stack that is not full
    a_wr_slot: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((wr_addr[IDX_W] ? top_b_reg : top_a_reg) < CNT_W'(DEPTH)))
        else $error("slot write into a full stack");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for dual_char_stack_engine_top: two stack models predict every result
// depends on dcs_pkg and the engine rtl; named test tasks share one sender and one result checker

module tb;

    import dcs_pkg::*;

    localparam int STK_DEPTH  = DEPTH_DEF;
    localparam int HALF_CLK   = 6;
    localparam int RESET_CYC  = 12;
    localparam int LIMIT_CYC  = 500000;
    // worst case: palindrome walk of a full stack plus the trip back to idle and a stalled output
    localparam int DRAIN_CYC  = 60;
    localparam int IDLE_PCT   = 35;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    // shadow copy of both stacks, index 0 is stack A and 1 is stack B
    logic [7:0] stk_mem [2][STK_DEPTH];
    int         stk_cnt [2];

    out_item_t  pending_q[$];   // predicted results in acceptance order
    out_item_t  want;
    int         err_count;
    int         items_sent;
    int         cycle_cnt;
    bit         no_idle;        // set during the stretch where neither side holds off

    dual_char_stack_engine_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #(HALF_CLK) clk = ~clk;

    // ------------------------------------------------------------------
    // stack model
    // ------------------------------------------------------------------

    // push is dropped silently when the stack is already full
    function automatic void stack_push(int s, logic [7:0] v);
        if (stk_cnt[s] < STK_DEPTH)
        begin
            stk_mem[s][stk_cnt[s]] = v;
            stk_cnt[s]++;
        end
    endfunction

    // empty stack hands back the fill character and stays as it is
    function automatic logic [7:0] stack_pop(int s);
        logic [7:0] v;
        if (stk_cnt[s] == 0)
            return FILL_CHAR;
        stk_cnt[s]--;
        v = stk_mem[s][stk_cnt[s]];
        stk_mem[s][stk_cnt[s]] = FILL_CHAR;
        return v;
    endfunction

    // applies one item to the shadow stacks and returns the result it should produce
    function automatic out_item_t stack_apply(in_item_t it);
        out_item_t  r;
        int         s;
        int         n;
        logic [7:0] v;
        r = '0;
        s = int'(it.stack_sel);
        case (it.opcode)
            OP_PUSH:
                stack_push(s, it.char_in);
            OP_POP:
                r.char_out = stack_pop(s);
            OP_XFER:
            begin
                // an empty source still moves a fill character, a full destination loses it
                v = stack_pop(s);
                r.char_out = v;
                stack_push(s ^ 1, v);
            end
            default:
            begin
                // empty and single-entry stacks count as mirrored
                n = stk_cnt[s];
                r.is_palindrome = 1'b1;
                for (int i = 0; i < n / 2; i++)
                begin
                    if (stk_mem[s][i] != stk_mem[s][n - 1 - i])
                        r.is_palindrome = 1'b0;
                end
            end
        endcase
        r.is_empty  = (stk_cnt[s] == 0);
        r.is_full   = (stk_cnt[s] >= STK_DEPTH);
        r.depth_now = 5'(stk_cnt[s]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // half the bytes come from a tiny alphabet so that random stacks mirror now and then
    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 1) == 0)
            return ($urandom_range(0, 1) == 0) ? 8'h61 : 8'h62;
        return 8'($urandom);
    endfunction

    // called at a rising edge; returns at the edge where the item is taken,
    // leaving valid high so the next item can follow without a bubble
    task automatic send_item(op_t op, logic sel, logic [7:0] ch);
        in_item_t it;
        int       gap;
        it.opcode    = op;
        it.stack_sel = sel;
        it.char_in   = ch;
        if (!no_idle && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        pending_q.push_back(stack_apply(it));
        items_sent++;
    endtask

    task automatic run_noise(int n);
        repeat (n)
            send_item(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_char());
    endtask

    // empty a stack, fill it with a mirrored string (sometimes spoiled) and ask the question
    task automatic run_mirror_seq(logic sel);
        logic [7:0] seq [STK_DEPTH];
        int         len;
        int         k;
        while (stk_cnt[sel] > 0)
            send_item(($urandom_range(0, 3) == 0) ? OP_XFER : OP_POP, sel, rand_char());
        // mostly short strings, sometimes longer ones up to the stack depth
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, STK_DEPTH) : $urandom_range(0, 8);
        for (int i = 0; i < (len + 1) / 2; i++)
        begin
            seq[i] = 8'($urandom);
            seq[len - 1 - i] = seq[i];
        end
        if (len >= 2 && $urandom_range(0, 2) == 0)
        begin
            k = $urandom_range(0, len - 1);
            seq[k] = seq[k] ^ 8'(1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < len; i++)
            send_item(OP_PUSH, sel, seq[i]);
        send_item(OP_PAL, sel, rand_char());
        if ($urandom_range(0, 1) == 0)
            run_noise($urandom_range(1, 4));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // pop, transfer and query on stacks that hold nothing
    task automatic test_empty_stacks();
        send_item(OP_POP,  1'b0, 8'h00);
        send_item(OP_PAL,  1'b1, 8'hff);
        // empty source: fill char lands on stack A
        send_item(OP_XFER, 1'b1, 8'h00);
        send_item(OP_PAL,  1'b0, 8'h00);
        send_item(OP_POP,  1'b0, 8'hff);
        send_item(OP_POP,  1'b1, 8'h55);
    endtask

    // smallest and largest bytes through push, transfer, query and pop
    task automatic test_byte_extremes();
        send_item(OP_PUSH, 1'b0, 8'h00);
        send_item(OP_PUSH, 1'b0, 8'hff);
        send_item(OP_PAL,  1'b0, 8'haa);
        send_item(OP_PUSH, 1'b1, 8'hff);
        send_item(OP_XFER, 1'b0, 8'h00);
        send_item(OP_PAL,  1'b1, 8'h00);
        send_item(OP_POP,  1'b1, 8'h00);
        send_item(OP_POP,  1'b1, 8'h00);
        send_item(OP_POP,  1'b0, 8'h00);
        send_item(OP_POP,  1'b0, 8'h00);
    endtask

    // full stack: extra push dropped, transfer into it loses the byte
    task automatic test_full_stack();
        logic [7:0] v;
        for (int i = 0; i < STK_DEPTH / 2; i++)
        begin
            v = 8'(8'h41 + i);
            stk_mem_tmp_push(v);
        end
        for (int i = STK_DEPTH / 2 - 1; i >= 0; i--)
            send_item(OP_PUSH, 1'b0, 8'(8'h41 + i));
        send_item(OP_PAL,  1'b0, 8'h00);
        send_item(OP_PUSH, 1'b0, 8'h7e);
        send_item(OP_PUSH, 1'b1, 8'h99);
        send_item(OP_XFER, 1'b1, 8'h00);
        send_item(OP_XFER, 1'b0, 8'h00);
        send_item(OP_PAL,  1'b0, 8'h00);
        while (stk_cnt[0] > 0)
            send_item(OP_POP, 1'b0, 8'h00);
        send_item(OP_POP,  1'b1, 8'h00);
    endtask

    task automatic stk_mem_tmp_push(logic [7:0] v);
        send_item(OP_PUSH, 1'b0, v);
    endtask

    // mostly well-formed stack sequences with random content, the rest noise
    task automatic test_random_mix(int n_items);
        int  start;
        logic sel;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            sel = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    run_mirror_seq(sel);
                4, 5:
                begin
                    // run one stack into its limit, then pile on more
                    while (stk_cnt[sel] < STK_DEPTH)
                        send_item(OP_PUSH, sel, rand_char());
                    repeat ($urandom_range(1, 3))
                        send_item(OP_PUSH, sel, rand_char());
                    send_item(OP_PAL, sel, rand_char());
                    send_item(OP_XFER, ~sel, rand_char());
                    repeat ($urandom_range(1, 6))
                        send_item(OP_POP, sel, rand_char());
                end
                default:
                    run_noise($urandom_range(10, 30));
            endcase
        end
    endtask

    // back-to-back traffic with both sides always willing
    task automatic test_no_idle(int n_items);
        int start;
        no_idle = 1'b1;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(0, 1) == 0)
                run_mirror_seq(1'($urandom_range(0, 1)));
            else
                run_noise($urandom_range(5, 20));
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver holds off about a third of the time except in the no-idle stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // every accepted result item is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result item with nothing predicted: %h", out_item);
                err_count++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (out_item.char_out !== want.char_out)
                begin
                    $error("char_out expected %0d actual %0d", want.char_out, out_item.char_out);
                    err_count++;
                end
                if (out_item.is_empty !== want.is_empty)
                begin
                    $error("is_empty expected %0d actual %0d", want.is_empty, out_item.is_empty);
                    err_count++;
                end
                if (out_item.is_full !== want.is_full)
                begin
                    $error("is_full expected %0d actual %0d", want.is_full, out_item.is_full);
                    err_count++;
                end
                if (out_item.is_palindrome !== want.is_palindrome)
                begin
                    $error("is_palindrome expected %0d actual %0d",
                           want.is_palindrome, out_item.is_palindrome);
                    err_count++;
                end
                if (out_item.depth_now !== want.depth_now)
                begin
                    $error("depth_now expected %0d actual %0d", want.depth_now, out_item.depth_now);
                    err_count++;
                end
            end
        end
    end

    // watchdog on total run length
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYC)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        no_idle    = 1'b0;
        err_count  = 0;
        items_sent = 0;
        for (int s = 0; s < 2; s++)
        begin
            stk_cnt[s] = 0;
            for (int i = 0; i < STK_DEPTH; i++)
                stk_mem[s][i] = FILL_CHAR;
        end

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stacks();
        test_byte_extremes();
        test_full_stack();
        test_random_mix(1250);
        test_no_idle(200);

        // stimulus done: release valid at the last accepting edge, then let results drain
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: dual_char_stack_engine_top.f
hw/rtl/dcs_pkg.sv
hw/rtl/dcs_stack_ram.sv
hw/rtl/dual_char_stack_engine_top.sv
tb/sv/tb.sv
